// File: design/sha0_pkg.sv
`default_nettype none

package sha0_pkg;

   // block geometry
   localparam int unsigned BLOCK_WORDS = 16;
   localparam logic [5:0]  LEN_FILL    = 6'd56;
   localparam logic [6:0]  ROUND_LAST  = 7'd79;
   localparam logic [2:0]  WORD_BYTES  = 3'd4;
   localparam logic [2:0]  DIGEST_LAST = 3'd4;

   // initial chaining words, entry 0 is h0
   localparam logic [4:0][31:0] INIT_CHAIN = {
      32'hc3d2_e1f0, 32'h1032_5476, 32'h98ba_dcfe, 32'hefcd_ab89, 32'h6745_2301
   };

   // round constants
   localparam logic [31:0] K_CHOOSE  = 32'h5a82_7999;
   localparam logic [31:0] K_PARITY1 = 32'h6ed9_eba1;
   localparam logic [31:0] K_MAJORITY = 32'h8f1b_bcdc;
   localparam logic [31:0] K_PARITY2 = 32'hca62_c1d6;

   // padding marker byte, left aligned
   localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

   // working variables of the compression
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } work_type;

   // outcome of one byte packing step
   typedef struct packed {
      logic [31:0] word;
      logic [31:0] rem_word;
      logic [2:0]  rem_count;
      logic [6:0]  fill_sum;
      logic        write;
   } pack_type;

endpackage

`default_nettype wire

// File: design/sha0_hash_engine_core.sv
`default_nettype none

// SHA-0 hash engine.
// Request channel (req_*): one message word per request, first byte in
// req_tdata[31:24], valid leading byte count in req_tdata[34:32] (values
// above four count as four), req_tlast on the last word of the message.
// Only the last word may carry fewer than four bytes; it may carry none.
// Response channel (rsp_*): after the last word the five digest words
// h0..h4 come out in order, rsp_tlast on h4.
// Flow: a word that fits the current buffer word is packed as it is taken;
// one that straddles a word boundary is finished in ST_PACK. Each full
// 64-byte block adds 80 rounds of the single round unit, one per cycle,
// plus one chaining add, and no word is taken meanwhile. The last word adds
// padding (a marker byte, zero fill up to the length field, the length
// field), one or two compressions, then the digest words.
// req_tready is high only while the engine waits for a word.
// Reset: chaining words return to their initial values, counts clear and
// the engine is ready in the next cycle. A stalled response holds its word;
// no request is taken until the fifth digest word is taken, after which
// the engine starts a new message from the initial values.
module sha0_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] message_word, [34:32] byte_count
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PACK   = 8'b0000_0010,
      ST_MARK   = 8'b0000_0100,
      ST_ZERO   = 8'b0000_1000,
      ST_LENGTH = 8'b0001_0000,
      ST_ROUND  = 8'b0010_0000,
      ST_ADD    = 8'b0100_0000,
      ST_OUTPUT = 8'b1000_0000
   } state_type;

   state_type                 state_ff, state_in;
   logic [31:0]               blk_ff [sha0_pkg::BLOCK_WORDS];
   logic [5:0]                fill_ff, fill_in;
   logic [63:0]               bitlen_ff, bitlen_in;
   logic [4:0][31:0]          chain_ff, chain_in;
   sha0_pkg::work_type        work_ff, work_in;
   logic [6:0]                round_ff, round_in;
   logic [31:0]               pend_word_ff, pend_word_in;
   logic [2:0]                pend_count_ff, pend_count_in;
   logic                      last_ff, last_in;
   logic                      mark_ff, mark_in;
   logic                      lenblk_ff, lenblk_in;
   logic [2:0]                out_idx_ff, out_idx_in;

   logic                      accept;
   logic [2:0]                req_count;
   logic [31:0]               src_word;
   logic [2:0]                src_count;
   logic                      pack_go;
   logic                      last_now;
   sha0_pkg::pack_type        pk;
   sha0_pkg::work_type        rnd_nxt;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign req_count  = (req_tdata[34:32] > sha0_pkg::WORD_BYTES) ? sha0_pkg::WORD_BYTES
                                                                : req_tdata[34:32];

   assign rsp_tvalid = (state_ff == ST_OUTPUT);
   assign rsp_tdata  = chain_ff[out_idx_ff];
   assign rsp_tlast  = (out_idx_ff == sha0_pkg::DIGEST_LAST);

   // source of the packing step
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            src_word  = req_tdata[31:0];
            src_count = req_count;
         end
         ST_PACK: begin
            src_word  = pend_word_ff;
            src_count = pend_count_ff;
         end
         ST_MARK: begin
            src_word  = sha0_pkg::PAD_MARKER;
            src_count = 3'd1;
         end
         ST_ZERO: begin
            src_word  = '0;
            src_count = sha0_pkg::WORD_BYTES;
         end
         default: begin
            src_word  = '0;
            src_count = 3'd0;
         end
      endcase
      pack_go = accept || (state_ff == ST_PACK) || (state_ff == ST_MARK)
             || ((state_ff == ST_ZERO) && (fill_ff != sha0_pkg::LEN_FILL));
      last_now = (state_ff == ST_IDLE) ? req_tlast : last_ff;
   end

   sha0_pack u_pack (
      .src_word  (src_word),
      .src_count (src_count),
      .fill      (fill_ff),
      .old_word  (blk_ff[fill_ff[5:2]]),
      .result    (pk)
   );

   sha0_round u_round (
      .work_cur (work_ff),
      .round    (round_ff),
      .w        (blk_ff[0]),
      .work_nxt (rnd_nxt)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      bitlen_in     = bitlen_ff;
      chain_in      = chain_ff;
      pend_word_in  = pend_word_ff;
      pend_count_in = pend_count_ff;
      last_in       = last_ff;
      mark_in       = mark_ff;
      lenblk_in     = lenblk_ff;
      out_idx_in    = out_idx_ff;

      // working variables load from the chain outside the rounds
      if (state_ff == ST_ROUND) begin
         work_in  = rnd_nxt;
         round_in = round_ff + 7'd1;
      end else begin
         work_in  = sha0_pkg::work_type'(chain_ff);
         work_in.a = chain_ff[0];
         work_in.b = chain_ff[1];
         work_in.c = chain_ff[2];
         work_in.d = chain_ff[3];
         work_in.e = chain_ff[4];
         round_in = 7'd0;
      end

      case (state_ff)
         ST_IDLE, ST_PACK: begin
            if (pack_go) begin
               if (state_ff == ST_IDLE) begin
                  bitlen_in = bitlen_ff + {58'd0, req_count, 3'b000};
                  last_in   = req_tlast;
               end
               pend_word_in  = pk.rem_word;
               pend_count_in = pk.rem_count;
               fill_in       = pk.fill_sum[5:0];
               if (pk.fill_sum[6]) begin
                  state_in = ST_ROUND;
               end else if (pk.rem_count != 3'd0) begin
                  state_in = ST_PACK;
               end else if (last_now) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MARK: begin
            fill_in  = pk.fill_sum[5:0];
            mark_in  = 1'b1;
            state_in = pk.fill_sum[6] ? ST_ROUND : ST_ZERO;
         end
         ST_ZERO: begin
            if (fill_ff == sha0_pkg::LEN_FILL) begin
               state_in = ST_LENGTH;
            end else begin
               fill_in  = pk.fill_sum[5:0];
               state_in = pk.fill_sum[6] ? ST_ROUND : ST_ZERO;
            end
         end
         ST_LENGTH: begin
            lenblk_in = 1'b1;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == sha0_pkg::ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            if (lenblk_ff) begin
               out_idx_in = 3'd0;
               state_in   = ST_OUTPUT;
            end else if (pend_count_ff != 3'd0) begin
               state_in = ST_PACK;
            end else if (mark_ff) begin
               state_in = ST_ZERO;
            end else if (last_ff) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTPUT: begin
            if (rsp_tready) begin
               if (out_idx_ff == sha0_pkg::DIGEST_LAST) begin
                  // back to the initial values for the next message
                  chain_in      = sha0_pkg::INIT_CHAIN;
                  fill_in       = 6'd0;
                  bitlen_in     = 64'd0;
                  pend_count_in = 3'd0;
                  last_in       = 1'b0;
                  mark_in       = 1'b0;
                  lenblk_in     = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= 6'd0;
         bitlen_ff     <= 64'd0;
         chain_ff      <= sha0_pkg::INIT_CHAIN;
         round_ff      <= 7'd0;
         pend_count_ff <= 3'd0;
         last_ff       <= 1'b0;
         mark_ff       <= 1'b0;
         lenblk_ff     <= 1'b0;
         out_idx_ff    <= 3'd0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bitlen_ff     <= bitlen_in;
         chain_ff      <= chain_in;
         round_ff      <= round_in;
         pend_count_ff <= pend_count_in;
         last_ff       <= last_in;
         mark_ff       <= mark_in;
         lenblk_ff     <= lenblk_in;
         out_idx_ff    <= out_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      pend_word_ff <= pend_word_in;
   end

   // block buffer: byte fill, length field, and schedule shift during rounds
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < sha0_pkg::BLOCK_WORDS - 1; i++) begin
            blk_ff[i] <= blk_ff[i + 1];
         end
         blk_ff[sha0_pkg::BLOCK_WORDS - 1] <= blk_ff[13] ^ blk_ff[8] ^ blk_ff[2] ^ blk_ff[0];
      end else if (state_ff == ST_LENGTH) begin
         blk_ff[14] <= bitlen_ff[63:32];
         blk_ff[15] <= bitlen_ff[31:0];
      end else if (pack_go && pk.write) begin
         blk_ff[fill_ff[5:2]] <= pk.word;
      end
   end

endmodule

`default_nettype wire

// File: design/sha0_pack.sv
`default_nettype none

// Merges the leading bytes of a word into the buffer word at the current
// fill position, up to the next word boundary; returns what is left over.
module sha0_pack (
   input  logic [31:0]       src_word,
   input  logic [2:0]        src_count,
   input  logic [5:0]        fill,
   input  logic [31:0]       old_word,
   output sha0_pkg::pack_type result
);

   localparam logic [31:0] ONES = '1;

   logic [1:0]  off;
   logic [2:0]  room;
   logic [2:0]  n;
   logic [2:0]  end_bytes;
   logic [4:0]  lo_sh;
   logic [5:0]  end_sh;
   logic [31:0] m_lo;
   logic [31:0] wmask;

   always_comb begin
      off       = fill[1:0];
      room      = sha0_pkg::WORD_BYTES - {1'b0, off};
      n         = (src_count < room) ? src_count : room;
      end_bytes = {1'b0, off} + n;
      lo_sh     = {off, 3'b000};
      end_sh    = {end_bytes, 3'b000};
      m_lo      = ONES >> lo_sh;
      wmask     = m_lo & ~(ONES >> end_sh);

      // bytes ahead of the fill point stay, bytes past the new ones clear
      result.word      = (old_word & ~m_lo) | ((src_word >> lo_sh) & wmask);
      result.rem_word  = src_word << {n, 3'b000};
      result.rem_count = src_count - n;
      result.fill_sum  = {1'b0, fill} + {4'b0000, n};
      result.write     = (n != 3'd0);
   end

endmodule

`default_nettype wire

// File: design/sha0_round.sv
`default_nettype none

// One compression round: selects f and k by round number.
module sha0_round (
   input  sha0_pkg::work_type work_cur,
   input  logic [6:0]         round,
   input  logic [31:0]        w,
   output sha0_pkg::work_type work_nxt
);

   logic [31:0] f;
   logic [31:0] k;

   always_comb begin
      case (round) inside
         [7'd0:7'd19]: begin
            f = (work_cur.b & work_cur.c) | (~work_cur.b & work_cur.d);
            k = sha0_pkg::K_CHOOSE;
         end
         [7'd20:7'd39]: begin
            f = work_cur.b ^ work_cur.c ^ work_cur.d;
            k = sha0_pkg::K_PARITY1;
         end
         [7'd40:7'd59]: begin
            f = (work_cur.b & work_cur.c) | (work_cur.b & work_cur.d)
              | (work_cur.c & work_cur.d);
            k = sha0_pkg::K_MAJORITY;
         end
         default: begin
            f = work_cur.b ^ work_cur.c ^ work_cur.d;
            k = sha0_pkg::K_PARITY2;
         end
      endcase

      work_nxt.a = {work_cur.a[26:0], work_cur.a[31:27]} + f + work_cur.e + k + w;
      work_nxt.b = work_cur.a;
      work_nxt.c = {work_cur.b[1:0], work_cur.b[31:2]};
      work_nxt.d = work_cur.c;
      work_nxt.e = work_cur.d;
   end

endmodule

`default_nettype wire

// File: design/sha0_checker.sv
`default_nettype none

// Port-level checks on the hash engine.
module sha0_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // engine never takes a request while a digest is on offer
   a_ready_vs_valid: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request ready while digest valid");

   // a stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled digest word changed");

   // a word that is not last never produces a digest next cycle
   a_no_early_digest: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !rsp_tvalid)
      else $error("digest after non-final request");

   // after the fifth digest word the engine is ready again
   a_ready_after_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("engine not ready after digest");

endmodule

bind sha0_hash_engine_core sha0_checker u_checker (.*);

`default_nettype wire
